### rtl/ntc_pkg.sv
// Shared constants, types and the thermistor table for the NTC sensor core.
package ntc_pkg;

  localparam int AvgDepth      = 100;
  localparam int TableEntries  = 141;
  localparam int ConvertPeriod = 100;
  localparam int DegOffset     = 10;

  localparam int SlotW = 7;
  localparam int SumW  = 19;
  localparam int IdxW  = 8;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_OPEN  = 3'd2;
  localparam logic [2:0] ST_BELOW = 3'd3;
  localparam logic [2:0] ST_ABOVE = 3'd4;

  localparam logic CFG_SHORT = 1'b0;
  localparam logic CFG_OPEN  = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic take;      // latch sample, read old slot
    logic upd_sum;   // ring write, sum update
    logic div_start;
    logic div_step;
    logic cls;       // classify / start search
    logic srch_step;
    logic interp;    // load interpolation divide
    logic idiv_step;
    logic finish;    // commit temperature
    logic emit;
  } ntc_cmd_t;

  typedef struct packed {
    logic conv_due;
    logic in_table;
    logic srch_done;
    logic div_done;
  } ntc_sts_t;

  function automatic logic [11:0] tab_at(input logic [IdxW-1:0] k);
    logic [11:0] v;
    case (k)
      8'd0: v = 12'd170;   8'd1: v = 12'd180;   8'd2: v = 12'd189;   8'd3: v = 12'd200;
      8'd4: v = 12'd210;   8'd5: v = 12'd221;   8'd6: v = 12'd233;   8'd7: v = 12'd245;
      8'd8: v = 12'd258;   8'd9: v = 12'd271;   8'd10: v = 12'd284;  8'd11: v = 12'd298;
      8'd12: v = 12'd313;  8'd13: v = 12'd328;  8'd14: v = 12'd344;  8'd15: v = 12'd361;
      8'd16: v = 12'd381;  8'd17: v = 12'd404;  8'd18: v = 12'd425;  8'd19: v = 12'd448;
      8'd20: v = 12'd474;  8'd21: v = 12'd492;  8'd22: v = 12'd516;  8'd23: v = 12'd548;
      8'd24: v = 12'd586;  8'd25: v = 12'd611;  8'd26: v = 12'd600;  8'd27: v = 12'd632;
      8'd28: v = 12'd654;  8'd29: v = 12'd682;  8'd30: v = 12'd710;  8'd31: v = 12'd734;
      8'd32: v = 12'd758;  8'd33: v = 12'd794;  8'd34: v = 12'd826;  8'd35: v = 12'd858;
      8'd36: v = 12'd892;  8'd37: v = 12'd928;  8'd38: v = 12'd960;  8'd39: v = 12'd994;
      8'd40: v = 12'd1034; 8'd41: v = 12'd1068; 8'd42: v = 12'd1104; 8'd43: v = 12'd1140;
      8'd44: v = 12'd1174; 8'd45: v = 12'd1216; 8'd46: v = 12'd1260; 8'd47: v = 12'd1294;
      8'd48: v = 12'd1331; 8'd49: v = 12'd1368; 8'd50: v = 12'd1410; 8'd51: v = 12'd1442;
      8'd52: v = 12'd1482; 8'd53: v = 12'd1520; 8'd54: v = 12'd1560; 8'd55: v = 12'd1603;
      8'd56: v = 12'd1640; 8'd57: v = 12'd1680; 8'd58: v = 12'd1720; 8'd59: v = 12'd1760;
      8'd60: v = 12'd1804; 8'd61: v = 12'd1842; 8'd62: v = 12'd1882; 8'd63: v = 12'd1920;
      8'd64: v = 12'd1958; 8'd65: v = 12'd1994; 8'd66: v = 12'd2035; 8'd67: v = 12'd2072;
      8'd68: v = 12'd2110; 8'd69: v = 12'd2140; 8'd70: v = 12'd2170; 8'd71: v = 12'd2206;
      8'd72: v = 12'd2241; 8'd73: v = 12'd2280; 8'd74: v = 12'd2316; 8'd75: v = 12'd2351;
      8'd76: v = 12'd2387; 8'd77: v = 12'd2418; 8'd78: v = 12'd2450; 8'd79: v = 12'd2487;
      8'd80: v = 12'd2522; 8'd81: v = 12'd2553; 8'd82: v = 12'd2587; 8'd83: v = 12'd2617;
      8'd84: v = 12'd2645; 8'd85: v = 12'd2674; 8'd86: v = 12'd2703; 8'd87: v = 12'd2732;
      8'd88: v = 12'd2764; 8'd89: v = 12'd2795; 8'd90: v = 12'd2824; 8'd91: v = 12'd2853;
      8'd92: v = 12'd2882; 8'd93: v = 12'd2904; 8'd94: v = 12'd2929; 8'd95: v = 12'd2959;
      8'd96: v = 12'd2982; 8'd97: v = 12'd3003; 8'd98: v = 12'd3028; 8'd99: v = 12'd3048;
      8'd100: v = 12'd3072; 8'd101: v = 12'd3098; 8'd102: v = 12'd3118; 8'd103: v = 12'd3138;
      8'd104: v = 12'd3160; 8'd105: v = 12'd3178; 8'd106: v = 12'd3196; 8'd107: v = 12'd3216;
      8'd108: v = 12'd3235; 8'd109: v = 12'd3255; 8'd110: v = 12'd3278; 8'd111: v = 12'd3308;
      8'd112: v = 12'd3354; 8'd113: v = 12'd3374; 8'd114: v = 12'd3384; 8'd115: v = 12'd3392;
      8'd116: v = 12'd3409; 8'd117: v = 12'd3426; 8'd118: v = 12'd3442; 8'd119: v = 12'd3458;
      8'd120: v = 12'd3473; 8'd121: v = 12'd3489; 8'd122: v = 12'd3503; 8'd123: v = 12'd3518;
      8'd124: v = 12'd3532; 8'd125: v = 12'd3545; 8'd126: v = 12'd3559; 8'd127: v = 12'd3572;
      8'd128: v = 12'd3585; 8'd129: v = 12'd3597; 8'd130: v = 12'd3609; 8'd131: v = 12'd3621;
      8'd132: v = 12'd3632; 8'd133: v = 12'd3643; 8'd134: v = 12'd3654; 8'd135: v = 12'd3665;
      8'd136: v = 12'd3675; 8'd137: v = 12'd3685; 8'd138: v = 12'd3695; 8'd139: v = 12'd3705;
      8'd140: v = 12'd3714;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/ntc_averaged_temperature_sensor_core.sv
// Top level of the NTC averaged temperature sensor core.
// Each tick latches a sample, reads the old slot and updates the running sum
// and the 100-sample mean, which comes from a reciprocal multiply. On every
// 100th tick the mean is classified and, when it lies in the table, converted
// by a table search of up to eight steps and a 19-step restoring divide.
// A stalled result holds the input off.
// After reset a clearing pass zeroes all 100 slots of the sample ring before the
// first tick is taken; configuration writes are accepted at any time and
// belong between ticks.
module ntc_averaged_temperature_sensor_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        adc_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        filtered_adc,
  output logic               converted,
  output logic [2:0]         sensor_status,
  output logic signed [11:0] temperature_tenths,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  ntc_pkg::ntc_cmd_t cmd;
  ntc_pkg::ntc_sts_t sts;
  logic clr_active;
  logic [ntc_pkg::SlotW-1:0] clr_addr;
  logic [11:0] short_threshold;
  logic [12:0] open_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_threshold <= 12'd15;
      open_threshold  <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ntc_pkg::CFG_SHORT: short_threshold <= cfg_data[11:0];
        ntc_pkg::CFG_OPEN:  open_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  ntc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts),
    .clr_active(clr_active), .clr_addr(clr_addr)
  );

  ntc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .clr_active(clr_active),
    .clr_addr(clr_addr), .adc_sample(adc_sample),
    .short_threshold(short_threshold), .open_threshold(open_threshold),
    .filtered_adc(filtered_adc), .converted(converted),
    .sensor_status(sensor_status), .temperature_tenths(temperature_tenths)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sensor_status <= ntc_pkg::ST_ABOVE)) else $error("bad status");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

### rtl/ntc_ram.sv
// Generic single-port RAM with registered read.
module ntc_ram #(
  parameter int Width = 12,
  parameter int Depth = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/ntc_datapath.sv
// Ring, running sum, mean, table search and interpolation datapath.
module ntc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  ntc_pkg::ntc_cmd_t    cmd,
  output ntc_pkg::ntc_sts_t    sts,
  input  logic                 clr_active,
  input  logic [ntc_pkg::SlotW-1:0] clr_addr,
  input  logic [11:0]          adc_sample,
  input  logic [11:0]          short_threshold,
  input  logic [12:0]          open_threshold,
  output logic [11:0]          filtered_adc,
  output logic                 converted,
  output logic [2:0]           sensor_status,
  output logic signed [11:0]   temperature_tenths
);
  localparam int SlotW = ntc_pkg::SlotW;
  localparam int SumW  = ntc_pkg::SumW;
  localparam int IdxW  = ntc_pkg::IdxW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(ntc_pkg::AvgDepth - 1);
  // ceil(2^26 / 100): exact quotient for any 19-bit sum
  localparam logic [19:0] MeanRecip = 20'd671089;

  logic [11:0] sample;
  logic [SlotW-1:0] write_slot, tick_count;
  logic [SumW-1:0] ring_sum;
  logic [11:0] slot0, last_slot;
  logic [11:0] old_val;

  logic ram_we;
  logic [SlotW-1:0] ram_addr;
  logic [11:0] ram_wdata;

  // mean of the ring by reciprocal multiply
  logic [38:0] mean_prod;

  // restoring divider for the interpolation
  logic [SumW-1:0] dq;
  logic [SumW-1:0] drem;
  logic [SumW-1:0] dden;
  logic [4:0] dcnt;
  logic [SumW:0] dtrial;

  logic [11:0] filt;
  logic [IdxW-1:0] lo, hi;
  logic [2:0] held_status;
  logic [11:0] held_temp;
  logic signed [11:0] base_t;

  assign ram_we    = clr_active || cmd.upd_sum;
  assign ram_addr  = clr_active ? clr_addr : write_slot;
  assign ram_wdata = clr_active ? 12'd0 : sample;

  ntc_ram #(.Width(12), .Depth(ntc_pkg::AvgDepth)) u_ring (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(old_val)
  );

  assign mean_prod = {20'd0, ring_sum} * {19'd0, MeanRecip};

  assign dtrial = {drem, dq[SumW-1]} - {1'b0, dden};

  logic [IdxW-1:0] mid;
  logic [11:0] t_hi, t_mid, t_lo;
  assign mid  = IdxW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign t_hi = ntc_pkg::tab_at(hi);
  assign t_mid = ntc_pkg::tab_at(mid);
  assign t_lo = ntc_pkg::tab_at(lo);

  assign sts.conv_due  = (tick_count == SlotW'(ntc_pkg::ConvertPeriod - 1));
  assign sts.in_table  = (held_status == ntc_pkg::ST_OK) && converted;
  assign sts.srch_done = (hi - lo) <= IdxW'(1);
  assign sts.div_done  = (dcnt == 5'd0);

  logic [SumW-1:0] num;
  always_comb begin
    // ((val-dl)*100+5)/10 == (val-dl)*10 exactly, so numerator is (val-dl)*10
    num = SumW'(({7'd0, filt} - {7'd0, t_lo}) * 19'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      tick_count <= '0;
      ring_sum   <= '0;
      slot0      <= '0;
      last_slot  <= '0;
      held_status <= ntc_pkg::ST_OK;
      held_temp  <= '0;
      converted  <= 1'b0;
      dcnt       <= '0;
      filtered_adc <= '0;
      sensor_status <= ntc_pkg::ST_OK;
      temperature_tenths <= '0;
    end else begin
      if (cmd.take) begin
        sample <= adc_sample;
      end
      if (cmd.upd_sum) begin
        ring_sum <= ring_sum - SumW'(old_val) + SumW'(sample);
        if (write_slot == '0) slot0 <= sample;
        if (write_slot == LastSlot) last_slot <= sample;
        write_slot <= (write_slot == LastSlot) ? '0 : write_slot + 1'b1;
        converted <= 1'b0;
      end
      if (cmd.div_start) begin
        dcnt <= 5'd1;
      end
      // ring_sum already holds this beat's sample here
      if (cmd.div_step) begin
        dq   <= SumW'(mean_prod[38:26]);
        dcnt <= 5'd0;
      end
      if (cmd.idiv_step) begin
        dq   <= {dq[SumW-2:0], ~dtrial[SumW]};
        drem <= dtrial[SumW] ? {drem[SumW-2:0], dq[SumW-1]} : dtrial[SumW-1:0];
        dcnt <= dcnt - 5'd1;
      end
      if (cmd.cls) begin
        filt <= (last_slot == 12'd0) ? slot0 : dq[11:0];
        tick_count <= '0;
        converted <= 1'b1;
        lo <= '0;
        hi <= IdxW'(ntc_pkg::TableEntries - 1);
        begin
          logic [11:0] f;
          f = (last_slot == 12'd0) ? slot0 : dq[11:0];
          if (f <= short_threshold) held_status <= ntc_pkg::ST_SHORT;
          else if ({1'b0, f} >= open_threshold) held_status <= ntc_pkg::ST_OPEN;
          else if (f < ntc_pkg::tab_at('0)) held_status <= ntc_pkg::ST_BELOW;
          else if (f > ntc_pkg::tab_at(IdxW'(ntc_pkg::TableEntries - 1)))
            held_status <= ntc_pkg::ST_ABOVE;
          else held_status <= ntc_pkg::ST_OK;
        end
      end else if (cmd.emit && !converted && cmd.take == 1'b0) begin
        filt <= filt;
      end
      if (cmd.div_start && !cmd.cls) begin
        tick_count <= tick_count + 1'b1;
      end
      if (cmd.srch_step) begin
        if (filt <= t_hi && filt > t_mid) lo <= mid;
        else hi <= mid;
      end
      base_t <= 12'(({4'd0, lo} - 12'(ntc_pkg::DegOffset)) * 12'd10);
      if (cmd.interp) begin
        dq   <= num;
        drem <= '0;
        dden <= SumW'(t_hi - t_lo);
        dcnt <= 5'(SumW);
      end
      if (cmd.finish) begin
        if (t_lo == filt)
          held_temp <= 12'(({4'd0, lo} - 12'(ntc_pkg::DegOffset)) * 12'd10);
        else if (t_hi == filt)
          held_temp <= 12'(({4'd0, hi} - 12'(ntc_pkg::DegOffset)) * 12'd10);
        else if (t_hi == t_lo)
          held_temp <= 12'(({4'd0, lo} - 12'(ntc_pkg::DegOffset)) * 12'd10);
        else
          held_temp <= base_t + dq[11:0];
      end
      if (cmd.emit) begin
        filtered_adc <= converted ? filt : ((last_slot == 12'd0) ? slot0 : dq[11:0]);
        sensor_status <= held_status;
        temperature_tenths <= (cmd.finish) ? temperature_tenths : held_temp;
      end
    end
  end
endmodule

### rtl/ntc_ctrl.sv
// Sequencing controller for the NTC sensor core.
module ntc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ntc_pkg::ntc_cmd_t cmd,
  input  ntc_pkg::ntc_sts_t sts,
  output logic              clr_active,
  output logic [ntc_pkg::SlotW-1:0] clr_addr
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_CLS   = 4'd5;
  localparam logic [3:0] S_SRCH  = 4'd6;
  localparam logic [3:0] S_IDIVL = 4'd7;
  localparam logic [3:0] S_IDIV  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state, state_next;
  logic conv;

  assign clr_active = (state == S_CLR);
  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLR:  if (clr_addr == ntc_pkg::SlotW'(ntc_pkg::AvgDepth - 1)) state_next = S_IDLE;
      S_IDLE: if (in_valid) begin
        cmd.take = 1'b1;
        state_next = S_RD;
      end
      S_RD:   state_next = S_UPD;
      S_UPD:  begin
        cmd.upd_sum = 1'b1;
        state_next = S_DIV;
      end
      S_DIV:  begin
        if (sts.div_done && conv) begin
          state_next = S_CLS;
        end else if (sts.div_done) begin
          state_next = S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_CLS:  begin
        cmd.cls = 1'b1;
        state_next = S_SRCH;
      end
      S_SRCH: begin
        if (!sts.in_table) state_next = S_EMIT;
        else if (sts.srch_done) state_next = S_IDIVL;
        else cmd.srch_step = 1'b1;
      end
      S_IDIVL: begin
        cmd.interp = 1'b1;
        state_next = S_IDIV;
      end
      S_IDIV: begin
        if (sts.div_done) state_next = S_FIN;
        else cmd.idiv_step = 1'b1;
      end
      S_FIN:  begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // divider start rides on the sum update
    if (state == S_UPD) cmd.div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      conv     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_addr <= clr_addr + 1'b1;
      if (state == S_UPD) conv <= sts.conv_due;
    end
  end
endmodule
